// File: src/ppf_pkg.sv
// ----------------------------------------------------------------------------
// ppf_pkg
// Shared widths, codes and reset values of the prebuffered playout fifo.
// ----------------------------------------------------------------------------
`default_nettype none

package ppf_pkg;

  localparam int SAMPLE_W = 16;
  localparam int LEN_W = 7;
  localparam int THR_W = 13;

  localparam logic [THR_W-1:0] THR_RESET = 13'd320;

  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_REQ  = 1'b1
  } opcode_t;

endpackage

`default_nettype wire

// File: src/ppf_ram.sv
// ----------------------------------------------------------------------------
// ppf_ram
// Sample store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ppf_ram #(
  parameter int DEPTH = 4096,
  parameter int ADDR_W = 12
) (
  input  wire logic                          clk,
  input  wire logic                          we,
  input  wire logic [ADDR_W-1:0]             waddr,
  input  wire logic [ppf_pkg::SAMPLE_W-1:0]  wdata,
  input  wire logic [ADDR_W-1:0]             raddr,
  output logic      [ppf_pkg::SAMPLE_W-1:0]  rdata
);

  logic [ppf_pkg::SAMPLE_W-1:0] mem [DEPTH];
  logic [ppf_pkg::SAMPLE_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// File: src/prebuffered_playout_fifo.sv
// ----------------------------------------------------------------------------
// prebuffered_playout_fifo
// Audio playout fifo with a prebuffer gate and zero padding on underrun.
// ----------------------------------------------------------------------------
// Input channel: an item is taken when start is high and busy is low.
//   A push (in_opcode = 0) stores in_sample_in and gives no
//   beat; a full fifo drops the sample and sets the sticky overrun flag.
//   A request (in_opcode = 1) asks for in_block_len samples (saturated to
//   MAX_BLOCK, zero gives nothing). busy stays high while the block is read.
// Output channel: each beat stands on the out_ ports for one cycle, marked by
//   out_valid. Once a request is taken the fsm enters its run state and the
//   first beat passes the output stage registers, then one beat per cycle;
//   a request holds the single read port of the sample memory for its block.
//   The next item may be taken while the final beat is on the ports.
// Idle playback answers with silence until the fill reaches the larger of
//   twice the block length and start_threshold; a playing block that runs
//   short is padded with silence, flagged as underrun, and playback stops.
// Reset (rst_n low, synchronous) empties the fifo, stops playback, clears
//   the overrun flag and loads start_threshold with 320. The memory itself
//   is not cleared; only written entries are read. The receiver cannot stall.
// cfg_we with cfg_wdata writes start_threshold; write it only while idle.
// ----------------------------------------------------------------------------
`default_nettype none

module prebuffered_playout_fifo #(
  parameter int FIFO_DEPTH = 4096,
  parameter int MAX_BLOCK = 64
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                start,
  output logic                                     busy,
  input  wire logic                                in_opcode,
  input  wire logic signed [ppf_pkg::SAMPLE_W-1:0] in_sample_in,
  input  wire logic        [ppf_pkg::LEN_W-1:0]    in_block_len,
  output logic                                     out_valid,
  output logic signed      [ppf_pkg::SAMPLE_W-1:0] out_sample_out,
  output logic                                     out_is_padding,
  output logic                                     out_underrun,
  output logic                                     out_overrun_seen,
  output logic                                     out_last,
  input  wire logic                                cfg_we,
  input  wire logic        [ppf_pkg::THR_W-1:0]    cfg_wdata
);

  localparam int PTR_W = $clog2(FIFO_DEPTH);
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
  localparam int CMP_W = ((CNT_W > ppf_pkg::THR_W) ? CNT_W : ppf_pkg::THR_W) + 1;
  localparam int LEN_W = ppf_pkg::LEN_W;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  state_t                     state_r, state_nxt;
  logic [PTR_W-1:0]           rd_ptr_r, rd_ptr_nxt;
  logic [PTR_W-1:0]           wr_ptr_r, wr_ptr_nxt;
  logic [CNT_W-1:0]           fill_r, fill_nxt;
  logic                       playing_r, playing_nxt;
  logic                       overrun_r, overrun_nxt;
  logic [ppf_pkg::THR_W-1:0]  thr_r, thr_nxt;
  logic [LEN_W-1:0]           len_r, len_nxt;
  logic [LEN_W-1:0]           take_r, take_nxt;
  logic                       under_r, under_nxt;
  logic [LEN_W-1:0]           idx_r, idx_nxt;

  logic                       ov_valid_r, ov_valid_nxt;
  logic                       ov_pad_r, ov_pad_nxt;
  logic                       ov_under_r, ov_under_nxt;
  logic                       ov_ovr_r, ov_ovr_nxt;
  logic                       ov_last_r, ov_last_nxt;

  logic                          accept;
  logic                          full;
  logic                          ram_we;
  logic [ppf_pkg::SAMPLE_W-1:0]  ram_rdata;
  logic [LEN_W-1:0]              len_sat;
  logic [CMP_W-1:0]              need;
  logic [CMP_W-1:0]              need_len;
  logic [CMP_W-1:0]              thr_ext;
  logic [CMP_W-1:0]              fill_ext;
  logic [CMP_W-1:0]              len_ext;
  logic                          pad_now;

  assign accept = start && (state_r == ST_IDLE);
  assign busy = (state_r == ST_RUN);
  assign full = (fill_r == CNT_W'(FIFO_DEPTH));
  assign ram_we = accept && (in_opcode == ppf_pkg::OP_PUSH) && !full;

  assign len_sat = (in_block_len > LEN_W'(MAX_BLOCK)) ? LEN_W'(MAX_BLOCK) : in_block_len;
  assign need_len = CMP_W'({len_sat, 1'b0});
  assign thr_ext = CMP_W'(thr_r);
  assign need = (thr_ext > need_len) ? thr_ext : need_len;
  assign fill_ext = CMP_W'(fill_r);
  assign len_ext = CMP_W'(len_sat);
  assign pad_now = (idx_r >= take_r);

  always_comb begin
    state_nxt    = state_r;
    rd_ptr_nxt   = rd_ptr_r;
    wr_ptr_nxt   = wr_ptr_r;
    fill_nxt     = fill_r;
    playing_nxt  = playing_r;
    overrun_nxt  = overrun_r;
    thr_nxt      = thr_r;
    len_nxt      = len_r;
    take_nxt     = take_r;
    under_nxt    = under_r;
    idx_nxt      = idx_r;
    ov_valid_nxt = 1'b0;
    ov_pad_nxt   = ov_pad_r;
    ov_under_nxt = ov_under_r;
    ov_ovr_nxt   = ov_ovr_r;
    ov_last_nxt  = ov_last_r;

    if (cfg_we) begin
      thr_nxt = cfg_wdata;
    end

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_opcode == ppf_pkg::OP_PUSH) begin
            if (full) begin
              overrun_nxt = 1'b1;
            end else begin
              wr_ptr_nxt = (wr_ptr_r == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
              fill_nxt = fill_r + 1'b1;
            end
          end else if (len_sat != '0) begin
            len_nxt = len_sat;
            idx_nxt = '0;
            state_nxt = ST_RUN;
            if (!playing_r && (fill_ext < need)) begin
              // prebuffering: whole block is silence
              take_nxt = '0;
              under_nxt = 1'b0;
            end else begin
              playing_nxt = 1'b1;
              if (fill_ext < len_ext) begin
                take_nxt = LEN_W'(fill_r);
                under_nxt = 1'b1;
                playing_nxt = 1'b0;
                fill_nxt = '0;
              end else begin
                take_nxt = len_sat;
                under_nxt = 1'b0;
                fill_nxt = fill_r - CNT_W'(len_sat);
              end
            end
          end
        end
      end
      ST_RUN: begin
        // one beat issued per cycle; memory data lands with the output stage
        ov_valid_nxt = 1'b1;
        ov_pad_nxt   = pad_now;
        ov_under_nxt = under_r;
        ov_ovr_nxt   = overrun_r;
        ov_last_nxt  = (idx_r == len_r - 1'b1);
        if (!pad_now) begin
          rd_ptr_nxt = (rd_ptr_r == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
        end
        idx_nxt = idx_r + 1'b1;
        if (idx_r == len_r - 1'b1) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      rd_ptr_r   <= '0;
      wr_ptr_r   <= '0;
      fill_r     <= '0;
      playing_r  <= 1'b0;
      overrun_r  <= 1'b0;
      thr_r      <= ppf_pkg::THR_RESET;
      ov_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      rd_ptr_r   <= rd_ptr_nxt;
      wr_ptr_r   <= wr_ptr_nxt;
      fill_r     <= fill_nxt;
      playing_r  <= playing_nxt;
      overrun_r  <= overrun_nxt;
      thr_r      <= thr_nxt;
      ov_valid_r <= ov_valid_nxt;
    end
    len_r      <= len_nxt;
    take_r     <= take_nxt;
    under_r    <= under_nxt;
    idx_r      <= idx_nxt;
    ov_pad_r   <= ov_pad_nxt;
    ov_under_r <= ov_under_nxt;
    ov_ovr_r   <= ov_ovr_nxt;
    ov_last_r  <= ov_last_nxt;
  end

  ppf_ram #(
    .DEPTH  (FIFO_DEPTH),
    .ADDR_W (PTR_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_ptr_r),
    .wdata (in_sample_in),
    .raddr (rd_ptr_r),
    .rdata (ram_rdata)
  );

  assign out_valid        = ov_valid_r;
  assign out_sample_out   = ov_pad_r ? '0 : $signed(ram_rdata);
  assign out_is_padding   = ov_pad_r;
  assign out_underrun     = ov_under_r;
  assign out_overrun_seen = ov_ovr_r;
  assign out_last         = ov_last_r;

endmodule

`default_nettype wire

// File: bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the prebuffered playout fifo. A directed table
// covers reset silence, field extremes, exact fill, underrun and a threshold
// beyond the depth. Random push bursts and block requests follow under
// several thresholds. Every beat is checked against a shadow model of the
// fifo and its playback gate, or against the beats typed into the table.
// ----------------------------------------------------------------------------
module testbench;

  localparam int SAMPLE_W = ppf_pkg::SAMPLE_W;
  localparam int LEN_W = ppf_pkg::LEN_W;
  localparam int THR_W = ppf_pkg::THR_W;
  localparam int FIFO_DEPTH = 4096;
  localparam int MAX_BLOCK = 64;
  localparam int CYCLE_LIMIT = 400000;
  localparam int RAND_PHASES = 5;
  localparam int PHASE_ITEMS = 52;
  localparam logic [THR_W-1:0] THR_MAX = '1;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                pad;
    logic                under;
    logic                ovr;
    logic                last;
  } beat_t;

  typedef struct {
    bit                  is_cfg;
    ppf_pkg::opcode_t    op;
    logic [SAMPLE_W-1:0] sample;
    logic [LEN_W-1:0]    len;
    logic [THR_W-1:0]    thr;
    bit                  typed;
    int                  t_count;
    bit                  t_under;
  } row_t;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       start = 1'b0;
  logic                       in_opcode = ppf_pkg::OP_PUSH;
  logic signed [SAMPLE_W-1:0] in_sample_in = '0;
  logic        [LEN_W-1:0]    in_block_len = '0;
  logic                       cfg_we = 1'b0;
  logic        [THR_W-1:0]    cfg_wdata = '0;
  logic                       busy;
  logic                       out_valid;
  logic signed [SAMPLE_W-1:0] out_sample_out;
  logic                       out_is_padding;
  logic                       out_underrun;
  logic                       out_overrun_seen;
  logic                       out_last;

  prebuffered_playout_fifo #(
    .FIFO_DEPTH(FIFO_DEPTH),
    .MAX_BLOCK (MAX_BLOCK)
  ) uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_opcode       (in_opcode),
    .in_sample_in    (in_sample_in),
    .in_block_len    (in_block_len),
    .out_valid       (out_valid),
    .out_sample_out  (out_sample_out),
    .out_is_padding  (out_is_padding),
    .out_underrun    (out_underrun),
    .out_overrun_seen(out_overrun_seen),
    .out_last        (out_last),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata)
  );

  always #1 clk = ~clk;

  // shadow copy of the fifo state
  logic [SAMPLE_W-1:0] shadow_mem [0:FIFO_DEPTH-1];
  int                  shadow_rd = 0;
  int                  shadow_wr = 0;
  int                  shadow_fill = 0;
  bit                  shadow_playing = 1'b0;
  bit                  shadow_overrun = 1'b0;
  logic [THR_W-1:0]    shadow_thr = ppf_pkg::THR_RESET;

  beat_t       due_beats [$];
  row_t        opening_rows [$];
  int          mismatches = 0;
  int unsigned cycles = 0;
  bit          pauses_on = 1'b0;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic [SAMPLE_W-1:0] got,
                                 input logic [SAMPLE_W-1:0] want);
    $display("mismatch on %s at cycle %0d: got %h, want %h", what, cycles, got, want);
    mismatches++;
  endtask

  // applies one item to the shadow state and queues the beats it yields
  function automatic int play_item(input ppf_pkg::opcode_t op,
                                   input logic [SAMPLE_W-1:0] smp,
                                   input logic [LEN_W-1:0] len_in);
    int len;
    int need;
    int take;
    int i;
    bit ran_short;
    if (op == ppf_pkg::OP_PUSH) begin
      if (shadow_fill >= FIFO_DEPTH) begin
        shadow_overrun = 1'b1;
      end else begin
        shadow_mem[shadow_wr] = smp;
        shadow_wr = (shadow_wr + 1) % FIFO_DEPTH;
        shadow_fill++;
      end
      return 0;
    end
    len = int'(len_in);
    if (len == 0) return 0;
    if (len > MAX_BLOCK) len = MAX_BLOCK;
    if (!shadow_playing) begin
      need = 2 * len;
      if (int'(shadow_thr) > need) need = int'(shadow_thr);
      if (shadow_fill < need) begin
        for (i = 0; i < len; i++) begin
          due_beats.push_back('{sample: '0, pad: 1'b1, under: 1'b0, ovr: shadow_overrun,
                                last: (i == len - 1)});
        end
        return len;
      end
      shadow_playing = 1'b1;
    end
    take = (shadow_fill < len) ? shadow_fill : len;
    ran_short = take < len;
    for (i = 0; i < take; i++) begin
      due_beats.push_back('{sample: shadow_mem[shadow_rd], pad: 1'b0, under: ran_short,
                            ovr: shadow_overrun, last: (i == len - 1)});
      shadow_rd = (shadow_rd + 1) % FIFO_DEPTH;
    end
    shadow_fill -= take;
    for (i = take; i < len; i++) begin
      due_beats.push_back('{sample: '0, pad: 1'b1, under: ran_short, ovr: shadow_overrun,
                            last: (i == len - 1)});
    end
    if (ran_short) shadow_playing = 1'b0;
    return len;
  endfunction

  function automatic row_t data_row(input ppf_pkg::opcode_t op,
                                    input logic [SAMPLE_W-1:0] smp,
                                    input logic [LEN_W-1:0] len);
    row_t r;
    r.is_cfg = 1'b0;
    r.op = op;
    r.sample = smp;
    r.len = len;
    r.thr = '0;
    r.typed = 1'b0;
    r.t_count = 0;
    r.t_under = 1'b0;
    return r;
  endfunction

  // request whose beats are all silence, typed in directly
  function automatic row_t quiet_row(input logic [LEN_W-1:0] len, input int count,
                                     input bit under);
    row_t r;
    r = data_row(ppf_pkg::OP_REQ, 16'h0f0f, len);
    r.typed = 1'b1;
    r.t_count = count;
    r.t_under = under;
    return r;
  endfunction

  function automatic row_t cfg_row(input logic [THR_W-1:0] thr);
    row_t r;
    r = data_row(ppf_pkg::OP_PUSH, '0, '0);
    r.is_cfg = 1'b1;
    r.thr = thr;
    return r;
  endfunction

  // holds start high until the item is taken; returns at the accepting edge
  task automatic issue_item(input ppf_pkg::opcode_t op, input logic [SAMPLE_W-1:0] smp,
                            input logic [LEN_W-1:0] len);
    start <= 1'b1;
    in_opcode <= op;
    in_sample_in <= smp;
    in_block_len <= len;
    @(negedge clk);
    while (busy) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic idle_gap(input int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic send_item(input ppf_pkg::opcode_t op, input logic [SAMPLE_W-1:0] smp,
                           input logic [LEN_W-1:0] len);
    issue_item(op, smp, len);
    void'(play_item(op, smp, len));
    if (pauses_on && $urandom_range(0, 4) == 0) idle_gap($urandom_range(1, 19));
  endtask

  task automatic write_threshold(input logic [THR_W-1:0] value);
    start <= 1'b0;
    while (due_beats.size() != 0) @(posedge clk);
    // a push gives no beat, so leave room for one still in flight
    repeat (4) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    shadow_thr = value;
  endtask

  always @(negedge clk) begin
    beat_t want;
    if (rst_n && out_valid) begin
      if (due_beats.size() == 0) begin
        report_mismatch("beat with nothing due", out_sample_out, '0);
      end else begin
        want = due_beats.pop_front();
        if (out_sample_out !== want.sample)
          report_mismatch("sample_out", out_sample_out, want.sample);
        if (out_is_padding !== want.pad)
          report_mismatch("is_padding", SAMPLE_W'(out_is_padding), SAMPLE_W'(want.pad));
        if (out_underrun !== want.under)
          report_mismatch("underrun", SAMPLE_W'(out_underrun), SAMPLE_W'(want.under));
        if (out_overrun_seen !== want.ovr)
          report_mismatch("overrun_seen", SAMPLE_W'(out_overrun_seen), SAMPLE_W'(want.ovr));
        if (out_last !== want.last)
          report_mismatch("last", SAMPLE_W'(out_last), SAMPLE_W'(want.last));
      end
    end
  end

  initial begin
    row_t             row;
    int               n;
    int               k;
    int               phase;
    int               sent;
    int               pushes;
    int               eff_len;
    int               pick;
    logic [LEN_W-1:0] len;
    logic [THR_W-1:0] thr;

    // idle after reset: silence, with zero length and saturation
    opening_rows.push_back(quiet_row(7'd0, 0, 1'b0));
    opening_rows.push_back(quiet_row(7'd1, 1, 1'b0));
    opening_rows.push_back(quiet_row(7'd64, 64, 1'b0));
    opening_rows.push_back(quiet_row(7'd127, 64, 1'b0));
    opening_rows.push_back(data_row(ppf_pkg::OP_PUSH, 16'h7fff, 7'h7f));
    opening_rows.push_back(data_row(ppf_pkg::OP_PUSH, 16'h8000, 7'h00));
    opening_rows.push_back(data_row(ppf_pkg::OP_PUSH, 16'h0000, 7'h2a));
    opening_rows.push_back(data_row(ppf_pkg::OP_PUSH, 16'hffff, 7'h55));
    opening_rows.push_back(data_row(ppf_pkg::OP_PUSH, 16'h1234, 7'h01));
    opening_rows.push_back(cfg_row('0));
    opening_rows.push_back(data_row(ppf_pkg::OP_REQ, 16'hffff, 7'd2));
    // drains the fifo exactly, playback stays on
    opening_rows.push_back(data_row(ppf_pkg::OP_REQ, 16'h0000, 7'd3));
    opening_rows.push_back(quiet_row(7'd4, 4, 1'b1));
    opening_rows.push_back(data_row(ppf_pkg::OP_PUSH, 16'h0007, 7'h10));
    opening_rows.push_back(quiet_row(7'd1, 1, 1'b0));
    opening_rows.push_back(data_row(ppf_pkg::OP_PUSH, 16'h0008, 7'h20));
    opening_rows.push_back(data_row(ppf_pkg::OP_REQ, 16'h7fff, 7'd1));
    opening_rows.push_back(data_row(ppf_pkg::OP_REQ, 16'h8000, 7'd2));
    // threshold past the depth keeps playback off
    opening_rows.push_back(cfg_row(THR_MAX));
    opening_rows.push_back(data_row(ppf_pkg::OP_PUSH, 16'h5a5a, 7'h40));
    opening_rows.push_back(data_row(ppf_pkg::OP_PUSH, 16'ha5a5, 7'h3f));
    opening_rows.push_back(quiet_row(7'd2, 2, 1'b0));
    opening_rows.push_back(cfg_row(ppf_pkg::THR_RESET));

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (opening_rows[i]) begin
      row = opening_rows[i];
      if (row.is_cfg) begin
        write_threshold(row.thr);
      end else begin
        issue_item(row.op, row.sample, row.len);
        n = play_item(row.op, row.sample, row.len);
        if (row.typed) begin
          repeat (n) void'(due_beats.pop_back());
          for (k = 0; k < row.t_count; k++) begin
            due_beats.push_back('{sample: '0, pad: 1'b1, under: row.t_under, ovr: 1'b0,
                                  last: (k == row.t_count - 1)});
          end
        end
      end
    end

    for (phase = 0; phase < RAND_PHASES; phase++) begin
      case (phase)
        0: begin
          thr = THR_W'($urandom_range(0, 24));
        end
        1: begin
          thr = THR_W'($urandom_range(1, 8));
        end
        2: begin
          thr = THR_W'($urandom_range(30, 80));
        end
        3: begin
          thr = '0;
        end
        default: begin
          thr = THR_W'($urandom_range(0, 16));
        end
      endcase
      write_threshold(thr);
      pauses_on = (phase != RAND_PHASES - 1);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        if ($urandom_range(0, 6) == 0) begin
          // noise: any opcode with any field values
          send_item(ppf_pkg::opcode_t'($urandom_range(0, 1)), SAMPLE_W'($urandom),
                    LEN_W'($urandom_range(0, 127)));
          sent++;
        end else begin
          // a burst of up to twice a block plus four pushes, then the block request
          pick = $urandom_range(0, 9);
          if (pick < 7) len = LEN_W'($urandom_range(1, 8));
          else if (pick < 9) len = LEN_W'($urandom_range(9, 64));
          else len = LEN_W'($urandom_range(65, 127));
          eff_len = (len > MAX_BLOCK) ? MAX_BLOCK : int'(len);
          pushes = $urandom_range(0, 2 * eff_len + 4);
          repeat (pushes) begin
            send_item(ppf_pkg::OP_PUSH, SAMPLE_W'($urandom), LEN_W'($urandom_range(0, 127)));
            sent++;
          end
          send_item(ppf_pkg::OP_REQ, SAMPLE_W'($urandom), len);
          sent++;
        end
      end
    end

    start <= 1'b0;
    while (due_beats.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
